// ----- hdl/vtwc_pkg.sv -----
package vtwc_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int TAB_COLUMNS   = 4;
    localparam int BYTE_BITS     = 8;
    localparam int M_TDATA_BITS  = 2 * COUNT_BITS;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [BYTE_BITS-1:0]  byte_t;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI,
        MODE_PCT,
        MODE_PCT_F,
        MODE_BRACE
    } scan_mode_t;

    // register index, taken from paddr[2]
    localparam logic REG_PROMPT_ESCAPES = 1'b0;

    localparam byte_t CH_TAB     = 8'h09;
    localparam byte_t CH_LF      = 8'h0A;
    localparam byte_t CH_VT      = 8'h0B;
    localparam byte_t CH_FF      = 8'h0C;
    localparam byte_t CH_CR      = 8'h0D;
    localparam byte_t CH_ESC     = 8'h1B;
    localparam byte_t CH_SPACE   = 8'h20;
    localparam byte_t CH_PERCENT = 8'h25;
    localparam byte_t CH_UPPER_B = 8'h42;
    localparam byte_t CH_UPPER_F = 8'h46;
    localparam byte_t CH_LBRACK  = 8'h5B;
    localparam byte_t CH_LOWER_B = 8'h62;
    localparam byte_t CH_LOWER_F = 8'h66;
    localparam byte_t CH_LBRACE  = 8'h7B;
    localparam byte_t CH_RBRACE  = 8'h7D;
    localparam byte_t CH_TILDE   = 8'h7E;
    localparam byte_t CSI_FINAL_LO = 8'h40;
    localparam byte_t UTF8_LEAD_MASK = 8'hC0;

    localparam count_t COUNT_MAX = '1;

    function automatic count_t sat_add(input count_t a, input count_t n);
        logic [COUNT_BITS:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, n};
            sat_add = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
        end
    endfunction

    // mode left behind by a byte handled from normal mode
    function automatic scan_mode_t plain_mode(input byte_t b, input logic prompt);
        begin
            if (b == CH_ESC)
                plain_mode = MODE_ESC;
            else if ((b & UTF8_LEAD_MASK) == UTF8_LEAD_MASK)
                plain_mode = MODE_NORMAL;
            else if (b == CH_PERCENT && prompt)
                plain_mode = MODE_PCT;
            else
                plain_mode = MODE_NORMAL;
        end
    endfunction

endpackage

// ----- hdl/visible_text_width_counter_core.sv -----
// channel | dir | tdata                               | tuser    | tlast
// s_*     | in  | [7:0] data_byte                     | has_byte | last
// m_*     | out | [15:0] visible_width, [31:16] lines | -        | -
// apb     | in  | reg 0 at 0x0: [0] prompt_escapes    | -        | -
//
// One byte per cycle sustained; a byte is taken every cycle the output is not stalled.
// A closing transfer reaches the result through the input register, then the result register.
// Only a tlast byte waits on a full result register; other bytes keep flowing.
// Reset clears scan state, counters (lines to 1), prompt_escapes; the register survives end of string.
module visible_text_width_counter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [vtwc_pkg::BYTE_BITS-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                                 s_tuser,   // [0] has_byte
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [vtwc_pkg::M_TDATA_BITS-1:0]    m_tdata,   // [15:0] visible_width, [31:16] line_count
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [vtwc_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [vtwc_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [vtwc_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import vtwc_pkg::*;

    logic       prompt_reg;
    logic       in_valid_reg;
    byte_t      in_byte_reg;
    logic       in_has_reg;
    logic       in_last_reg;
    scan_mode_t mode_reg, mode_next, mode_step;
    count_t     col_reg, col_next;
    count_t     widest_reg, widest_next;
    count_t     lines_reg, lines_next;
    logic       out_valid_reg;
    count_t     out_width_reg, out_width_next;
    count_t     out_lines_reg;

    logic   fire;
    logic   out_free;
    logic   do_plain;
    count_t pre_add, plain_add, fin_add;
    count_t col_a, col_b, col_c;
    logic   close_line, line_inc;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROMPT_ESCAPES)
                  ? {{(CFG_DATA_BITS-1){1'b0}}, prompt_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prompt_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_PROMPT_ESCAPES)
            prompt_reg <= pwdata[0];
    end

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // next scan mode
    always_comb
    begin
        mode_step = mode_reg;
        if (in_has_reg)
        begin
            case (mode_reg)
                MODE_ESC:
                    mode_step = (in_byte_reg == CH_LBRACK) ? MODE_CSI
                              : plain_mode(in_byte_reg, prompt_reg);
                MODE_CSI:
                    if (in_byte_reg inside {[CSI_FINAL_LO:CH_TILDE]})
                        mode_step = MODE_NORMAL;
                MODE_PCT:
                    if (in_byte_reg == CH_UPPER_F)
                        mode_step = MODE_PCT_F;
                    else if (in_byte_reg inside {CH_LOWER_F, CH_LOWER_B, CH_UPPER_B, CH_PERCENT})
                        mode_step = MODE_NORMAL;
                    else
                        mode_step = plain_mode(in_byte_reg, prompt_reg);
                MODE_PCT_F:
                    mode_step = (in_byte_reg == CH_LBRACE) ? MODE_BRACE
                              : plain_mode(in_byte_reg, prompt_reg);
                MODE_BRACE:
                    if (in_byte_reg == CH_RBRACE)
                        mode_step = MODE_NORMAL;
                default:
                    mode_step = plain_mode(in_byte_reg, prompt_reg);
            endcase
        end
        mode_next = in_last_reg ? MODE_NORMAL : mode_step;
    end

    // counter datapath
    always_comb
    begin
        pre_add  = '0;
        do_plain = 1'b0;
        if (in_has_reg)
        begin
            case (mode_reg)
                MODE_ESC:
                    do_plain = (in_byte_reg != CH_LBRACK);
                MODE_CSI,
                MODE_BRACE:
                    do_plain = 1'b0;
                MODE_PCT:
                    if (in_byte_reg == CH_PERCENT)
                        pre_add = count_t'(1);
                    else if (!(in_byte_reg inside {CH_UPPER_F, CH_LOWER_F, CH_LOWER_B, CH_UPPER_B}))
                    begin
                        pre_add  = count_t'(1);
                        do_plain = 1'b1;
                    end
                MODE_PCT_F:
                    if (in_byte_reg != CH_LBRACE)
                    begin
                        pre_add  = count_t'(2);
                        do_plain = 1'b1;
                    end
                default:
                    do_plain = 1'b1;
            endcase
        end

        plain_add  = '0;
        close_line = 1'b0;
        line_inc   = 1'b0;
        if (do_plain && in_byte_reg != CH_ESC)
        begin
            if ((in_byte_reg & UTF8_LEAD_MASK) == UTF8_LEAD_MASK)
                plain_add = count_t'(1);
            else if (in_byte_reg == CH_PERCENT && prompt_reg)
                plain_add = '0;
            else if (in_byte_reg == CH_TAB)
                plain_add = count_t'(TAB_COLUMNS);
            else if (in_byte_reg == CH_LF)
            begin
                close_line = 1'b1;
                line_inc   = 1'b1;
            end
            else if (in_byte_reg == CH_VT || in_byte_reg == CH_FF)
                line_inc = 1'b1;
            else if (in_byte_reg == CH_CR)
                close_line = 1'b1;
            else if (in_byte_reg inside {[CH_SPACE:CH_TILDE]})
                plain_add = count_t'(1);
        end

        col_a       = sat_add(col_reg, pre_add);
        col_b       = close_line ? '0 : sat_add(col_a, plain_add);
        widest_next = (close_line && col_a > widest_reg) ? col_a : widest_reg;
        lines_next  = line_inc ? sat_add(lines_reg, count_t'(1)) : lines_reg;

        // pending percent escape at end of string counts as text
        case (mode_step)
            MODE_PCT:   fin_add = count_t'(1);
            MODE_PCT_F: fin_add = count_t'(2);
            default:    fin_add = '0;
        endcase
        col_c          = sat_add(col_b, fin_add);
        out_width_next = (col_c > widest_next) ? col_c : widest_next;
        col_next       = col_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            col_reg    <= '0;
            widest_reg <= '0;
            lines_reg  <= count_t'(1);
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            if (in_last_reg)
            begin
                col_reg    <= '0;
                widest_reg <= '0;
                lines_reg  <= count_t'(1);
            end
            else
            begin
                col_reg    <= col_next;
                widest_reg <= widest_next;
                lines_reg  <= lines_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_last_reg)
        begin
            out_width_reg <= out_width_next;
            out_lines_reg <= lines_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_lines_reg, out_width_reg};

endmodule

// ----- hdl/vtwc_checker.sv -----
module vtwc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [vtwc_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import vtwc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input only backs up behind a full, stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // line count starts at one
    a_lines_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_BITS-1:COUNT_BITS] != '0)
        else $error("line count of zero");

    // a non-last transfer into an idle block never makes the result valid
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && !m_tvalid ##1 s_tready && !m_tvalid
        |=> !m_tvalid)
        else $error("result without a closing transfer");

endmodule

bind visible_text_width_counter_core vtwc_checker u_vtwc_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import vtwc_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SAT_TABS     = 16400;
    localparam int SAT_BREAKS   = 65540;

    typedef struct packed {
        count_t lines;
        count_t width;
    } text_extent_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        byte_t     data;
        logic      has;
        logic      last;
        logic      typed;
        count_t    w;
        count_t    l;
    } stim_row_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    byte_t                    s_tdata  = '0;    // [7:0] data_byte
    logic                     s_tuser  = 1'b0;  // [0] has_byte
    logic                     s_tlast  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_tdata;          // [15:0] visible_width, [31:16] line_count
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr    = '0;
    logic [CFG_DATA_BITS-1:0] pwdata   = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    visible_text_width_counter_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // scan state mirror
    scan_mode_t mdl_mode   = MODE_NORMAL;
    count_t     mdl_col    = '0;
    count_t     mdl_widest = '0;
    count_t     mdl_lines  = count_t'(1);
    logic       mdl_prompt = 1'b0;

    text_extent_t extent_q [$];

    int fail_count   = 0;
    int cycles       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int since_cfg    = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_orders  = 0;
    int hold_taken   = 0;
    int hold_left    = 0;

    stim_row_t dir_rows [0:34] = '{
        // prompt escapes off after reset: percent is plain text
        '{ROW_ITEM, CH_PERCENT, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_LOWER_F, 1'b1, 1'b1, 1'b1, 16'd2, 16'd1},
        // bare end marker, then an ignored transfer
        '{ROW_ITEM, 8'h00,      1'b0, 1'b1, 1'b1, 16'd0, 16'd1},
        '{ROW_ITEM, 8'h41,      1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_CFG,  8'h01,      1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        // CSI sequence, lone ESC, UTF-8, controls
        '{ROW_ITEM, CH_ESC,     1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_LBRACK,  1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, 8'h31,      1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, 8'h6D,      1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_ESC,     1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_UPPER_B, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, 8'hC3,      1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, 8'h80,      1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_TAB,     1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, 8'h7F,      1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_CR,      1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_LF,      1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_VT,      1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_FF,      1'b1, 1'b1, 1'b1, 16'd6, 16'd4},
        // percent escapes, pending percent at end
        '{ROW_ITEM, CH_PERCENT, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_UPPER_F, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_LBRACE,  1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_RBRACE,  1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_PERCENT, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_PERCENT, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_PERCENT, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0},
        // mode dropped after a percent has started
        '{ROW_ITEM, CH_PERCENT, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_CFG,  8'h00,      1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_UPPER_B, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_PERCENT, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0},
        // open CSI at end, pending %F at end
        '{ROW_ITEM, CH_ESC,     1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_LBRACK,  1'b1, 1'b1, 1'b1, 16'd0, 16'd1},
        '{ROW_CFG,  8'h01,      1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_PERCENT, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{ROW_ITEM, CH_UPPER_F, 1'b1, 1'b1, 1'b1, 16'd2, 16'd1}
    };

    function automatic count_t add_sat(count_t a, count_t n);
        return (a > COUNT_MAX - n) ? COUNT_MAX : count_t'(a + n);
    endfunction

    function automatic void end_line();
        if (mdl_col > mdl_widest)
            mdl_widest = mdl_col;
        mdl_col = '0;
    endfunction

    function automatic void scan_fresh(byte_t b);
        mdl_mode = MODE_NORMAL;
        if (b == CH_ESC)
            mdl_mode = MODE_ESC;
        else if ((b & UTF8_LEAD_MASK) == UTF8_LEAD_MASK)
            mdl_col = add_sat(mdl_col, count_t'(1));
        else if (b == CH_PERCENT && mdl_prompt)
            mdl_mode = MODE_PCT;
        else if (b == CH_TAB)
            mdl_col = add_sat(mdl_col, count_t'(TAB_COLUMNS));
        else if (b == CH_LF)
        begin
            end_line();
            mdl_lines = add_sat(mdl_lines, count_t'(1));
        end
        else if (b == CH_VT || b == CH_FF)
            mdl_lines = add_sat(mdl_lines, count_t'(1));
        else if (b == CH_CR)
            end_line();
        else if (b >= CH_SPACE && b <= CH_TILDE)
            mdl_col = add_sat(mdl_col, count_t'(1));
    endfunction

    function automatic void scan_byte(byte_t b);
        case (mdl_mode)
            MODE_ESC:
                if (b == CH_LBRACK)
                    mdl_mode = MODE_CSI;
                else
                    scan_fresh(b);
            MODE_CSI:
                if (b >= CSI_FINAL_LO && b <= CH_TILDE)
                    mdl_mode = MODE_NORMAL;
            MODE_PCT:
                if (b == CH_UPPER_F)
                    mdl_mode = MODE_PCT_F;
                else if (b == CH_LOWER_F || b == CH_LOWER_B || b == CH_UPPER_B)
                    mdl_mode = MODE_NORMAL;
                else if (b == CH_PERCENT)
                begin
                    mdl_mode = MODE_NORMAL;
                    mdl_col = add_sat(mdl_col, count_t'(1));
                end
                else
                begin
                    mdl_col = add_sat(mdl_col, count_t'(1));
                    scan_fresh(b);
                end
            MODE_PCT_F:
                if (b == CH_LBRACE)
                    mdl_mode = MODE_BRACE;
                else
                begin
                    mdl_col = add_sat(mdl_col, count_t'(2));
                    scan_fresh(b);
                end
            MODE_BRACE:
                if (b == CH_RBRACE)
                    mdl_mode = MODE_NORMAL;
            default:
                scan_fresh(b);
        endcase
    endfunction

    // returns 1 when the transfer closes the string
    function automatic logic measure_text(byte_t b, logic has, logic last,
                                          output text_extent_t ext);
        ext = '0;
        if (has)
            scan_byte(b);
        if (!last)
            return 1'b0;
        if (mdl_mode == MODE_PCT)
            mdl_col = add_sat(mdl_col, count_t'(1));
        else if (mdl_mode == MODE_PCT_F)
            mdl_col = add_sat(mdl_col, count_t'(2));
        ext.width = (mdl_col > mdl_widest) ? mdl_col : mdl_widest;
        ext.lines = mdl_lines;
        mdl_mode   = MODE_NORMAL;
        mdl_col    = '0;
        mdl_widest = '0;
        mdl_lines  = count_t'(1);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= 20)
            $display("MISMATCH cycle %0d: %s", cycles, what);
    endtask

    // result side: random or held-off tready, compare on every transfer
    always @(posedge clk)
    begin
        text_extent_t want;
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (extent_q.size() == 0)
                report_mismatch("result with nothing outstanding");
            else
            begin
                want = extent_q.pop_front();
                if (m_tdata[COUNT_BITS-1:0] !== want.width)
                    report_mismatch($sformatf("width got %0d want %0d",
                                              m_tdata[COUNT_BITS-1:0], want.width));
                if (m_tdata[M_TDATA_BITS-1:COUNT_BITS] !== want.lines)
                    report_mismatch($sformatf("lines got %0d want %0d",
                                              m_tdata[M_TDATA_BITS-1:COUNT_BITS], want.lines));
            end
        end
        if (hold_orders != hold_taken)
        begin
            hold_taken <= hold_orders;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // called at a clock edge; returns at the edge of the transfer
    task automatic send_item(byte_t d, logic has, logic last, logic typed,
                             text_extent_t typed_ext);
        text_extent_t ext;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= has;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (measure_text(d, has, last, ext))
            extent_q.push_back(typed ? typed_ext : ext);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (extent_q.size() != 0)
            @(posedge clk);
        // non-final bytes may still sit in the input register
        repeat (4) @(posedge clk);
    endtask

    task automatic set_prompt(logic v);
        logic [CFG_DATA_BITS-1:0] wv;
        wait_idle();
        wv    = $urandom;
        wv[0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PROMPT_ESCAPES, 2'b00};
        pwdata  <= wv;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        mdl_prompt = v;
        cfg_writes++;
        since_cfg = 0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== v)
            report_mismatch($sformatf("prompt_escapes read %0b want %0b", prdata[0], v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one string of random tokens, mostly well formed, with noise mixed in
    task automatic send_text();
        byte_t txt [$];
        int    ntok;
        int    k;
        int    j;
        int    n;
        logic  bare;
        logic  last;
        ntok = $urandom_range(1, 8);
        for (k = 0; k < ntok; k++)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) txt.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
                end
                1:
                begin
                    txt.push_back(byte_t'($urandom_range(8'hC0, 8'hFF)));
                    n = $urandom_range(0, 3);
                    repeat (n) txt.push_back(byte_t'($urandom_range(8'h80, 8'hBF)));
                end
                2:
                begin
                    txt.push_back(CH_ESC);
                    txt.push_back(CH_LBRACK);
                    n = $urandom_range(0, 3);
                    repeat (n) txt.push_back(byte_t'($urandom_range(8'h30, 8'h3F)));
                    txt.push_back(byte_t'($urandom_range(CSI_FINAL_LO, CH_TILDE)));
                end
                3:
                begin
                    txt.push_back(CH_PERCENT);
                    txt.push_back(CH_UPPER_F);
                    txt.push_back(CH_LBRACE);
                    n = $urandom_range(0, 3);
                    repeat (n) txt.push_back(byte_t'($urandom_range(8'h20, 8'h7C)));
                    txt.push_back(CH_RBRACE);
                end
                4:
                begin
                    txt.push_back(CH_PERCENT);
                    case ($urandom_range(0, 3))
                        0: txt.push_back(CH_LOWER_F);
                        1: txt.push_back(CH_LOWER_B);
                        2: txt.push_back(CH_UPPER_B);
                        default: txt.push_back(CH_PERCENT);
                    endcase
                end
                5:
                    case ($urandom_range(0, 4))
                        0: txt.push_back(CH_TAB);
                        1: txt.push_back(CH_LF);
                        2: txt.push_back(CH_CR);
                        3: txt.push_back(CH_VT);
                        default: txt.push_back(CH_FF);
                    endcase
                6:
                    txt.push_back(byte_t'($urandom));
                7:
                begin
                    txt.push_back(CH_ESC);
                    txt.push_back(byte_t'($urandom));
                end
                8:
                begin
                    txt.push_back(CH_PERCENT);
                    if ($urandom_range(0, 1))
                        txt.push_back(CH_UPPER_F);
                    txt.push_back(byte_t'($urandom));
                end
                9:
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            txt.push_back(CH_ESC);
                            txt.push_back(CH_LBRACK);
                        end
                        1:
                        begin
                            txt.push_back(CH_PERCENT);
                            txt.push_back(CH_UPPER_F);
                            txt.push_back(CH_LBRACE);
                        end
                        2:
                        begin
                            txt.push_back(CH_PERCENT);
                            txt.push_back(CH_UPPER_F);
                        end
                        default:
                            txt.push_back(CH_PERCENT);
                    endcase
                10:
                    txt.push_back($urandom_range(0, 1) ? 8'h7F
                                  : byte_t'($urandom_range(8'h00, 8'h1F)));
                default:
                    txt.push_back(byte_t'($urandom_range(8'h80, 8'hBF)));
            endcase
        end
        bare = ($urandom_range(0, 3) == 0);
        for (j = 0; j < txt.size(); j++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(byte_t'($urandom), 1'b0, 1'b0, 1'b0, '0);
            last = !bare && (j == txt.size() - 1);
            send_item(txt[j], 1'b1, last, 1'b0, '0);
            items_sent++;
            since_cfg++;
            // lands mid-string as often as not
            if (since_cfg >= 60)
                set_prompt($urandom_range(0, 1));
        end
        if (bare)
        begin
            send_item(byte_t'($urandom), 1'b0, 1'b1, 1'b0, '0);
            items_sent++;
        end
    endtask

    initial
    begin
        int r;
        int ph;
        int k;
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 28;
        sink_idle_pct <= 77;
        for (r = 0; r < $size(dir_rows); r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                set_prompt(dir_rows[r].data[0]);
            else
            begin
                send_item(dir_rows[r].data, dir_rows[r].has, dir_rows[r].last,
                          dir_rows[r].typed, text_extent_t'({dir_rows[r].l, dir_rows[r].w}));
                items_sent++;
            end
        end

        // receiver holds off while short strings keep coming, then sender drains
        wait_idle();
        src_idle_pct = 0;
        hold_orders <= hold_orders + 1;
        for (k = 0; k < 24; k++)
        begin
            send_item(byte_t'($urandom_range(8'h20, 8'h7E)), 1'b1, 1'b1, 1'b0, '0);
            items_sent++;
        end
        wait_idle();

        for (ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 77 : 0;
            sink_idle_pct <= (ph == 0) ? 77 : (ph == 1) ? 28 : 0;
            set_prompt($urandom_range(0, 1));
            target = items_sent + 190;
            while (items_sent < target)
                send_text();
        end

        // drive both counters into saturation
        set_prompt(1'b1);
        for (k = 0; k < SAT_TABS; k++)
            send_item(CH_TAB, 1'b1, 1'b0, 1'b0, '0);
        for (k = 0; k < SAT_BREAKS; k++)
            send_item((k % 3 == 0) ? CH_LF : (k % 3 == 1) ? CH_VT : CH_FF,
                      1'b1, 1'b0, 1'b0, '0);
        send_item(8'h61, 1'b1, 1'b1, 1'b1, text_extent_t'({COUNT_MAX, COUNT_MAX}));
        items_sent++;

        wait_idle();
        repeat (8) @(posedge clk);
        $display("text bytes: %0d short-string transfers plus a saturating string, %0d results",
                 items_sent, results_seen);
        $display("prompt mode written %0d times, incl. mid-string, under three idle mixes",
                 cfg_writes);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
